### rtl/imu_sample_calibrator_unit_macros.svh
// Assertion macros used by the calibrator top module.
// No dependencies.
`ifndef IMU_SAMPLE_CALIBRATOR_UNIT_MACROS_SVH
`define IMU_SAMPLE_CALIBRATOR_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ISC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ISC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/isc_pkg.sv
// Package for the IMU sample calibrator: payload types, constants, helpers.
// No dependencies.
package isc_pkg;
    localparam int WarmupSamplesDef = 20;
    localparam int CoeffWidthDef = 32;
    localparam int TableDepth = 48;
    localparam int TableAw = 6;
    localparam logic [7:0] KindAccel = 8'd1;
    localparam logic [7:0] KindGyro = 8'd2;
    localparam logic [1:0] RegDrift = 2'd0;
    localparam logic [1:0] RegAssembly = 2'd1;
    localparam logic [1:0] RegPresent = 2'd2;

    typedef struct packed {
        logic               action;
        logic [7:0]         sensor_kind;
        logic signed [15:0] raw_temperature;
        logic signed [15:0] raw_axis_x;
        logic signed [15:0] raw_axis_y;
        logic signed [15:0] raw_axis_z;
        logic [31:0]        sample_time;
        logic [5:0]         coeff_index;
        logic signed [31:0] coeff_value;
    } t_in_item;

    typedef struct packed {
        logic               out_kind;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_temperature;
        logic [31:0]        out_time;
    } t_out_item;

    typedef enum logic [1:0] {
        LOP_DRIFT = 2'd0,
        LOP_MAT   = 2'd1,
        LOP_DOT   = 2'd2
    } t_lane_op;

    typedef struct packed {
        logic     start;
        t_lane_op op;
    } t_lane_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        if (v > 67'sd2147483647) return 32'sh7fffffff;
        if (v < -67'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

### rtl/isc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module isc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/isc_lane.sv
// One arithmetic lane: three-term multiply-accumulate, one term at a time, rounded and
// saturated; in drift mode the rounded sum is subtracted from the base. Depends on isc_pkg.
module isc_lane
    import isc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_ctl          i_ctl,
    input  logic signed [31:0] i_a0,
    input  logic signed [31:0] i_a1,
    input  logic signed [31:0] i_a2,
    input  logic signed [31:0] i_b0,
    input  logic signed [31:0] i_b1,
    input  logic signed [31:0] i_b2,
    input  logic signed [31:0] i_base,
    output logic               o_done,
    output logic signed [31:0] o_res
);
    logic [1:0]         r_step;
    logic               r_busy;
    t_lane_op           r_op;
    logic signed [31:0] r_a [3];
    logic signed [31:0] r_b [3];
    logic signed [31:0] r_base;
    logic signed [63:0] r_prod;
    logic signed [66:0] r_acc;
    logic               r_pv;
    logic [1:0]         r_pcnt;
    logic signed [31:0] r_res;
    logic               r_done;
    logic signed [66:0] n_term;
    logic signed [66:0] w_acc;
    logic signed [66:0] w_fin;

    always_comb begin
        if (r_op == LOP_DRIFT) begin
            n_term = 67'(r_prod);
        end else begin
            n_term = 67'(r_prod >>> 2);
        end
        w_acc = r_acc + n_term;
        if (r_op == LOP_DRIFT) begin
            w_fin = 67'(r_base) - ((w_acc + (67'sd1 <<< 23)) >>> 24);
        end else begin
            w_fin = (w_acc + (67'sd1 <<< 21)) >>> 22;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
            r_pcnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_pcnt <= '0;
                r_op   <= i_ctl.op;
                r_a[0] <= i_a0; r_a[1] <= i_a1; r_a[2] <= i_a2;
                r_b[0] <= i_b0; r_b[1] <= i_b1; r_b[2] <= i_b2;
                r_base <= i_base;
                r_acc  <= '0;
                r_pv   <= 1'b0;
            end else begin
                r_pv <= r_busy;
                if (r_busy) begin
                    r_prod <= r_a[r_step] * r_b[r_step];
                    if (r_step == 2'd2) begin
                        r_busy <= 1'b0;
                    end
                    r_step <= r_step + 2'd1;
                end
                if (r_pv) begin
                    r_acc  <= w_acc;
                    r_pcnt <= r_pcnt + 2'd1;
                    if (r_pcnt == 2'd2) begin
                        r_res  <= sat32(w_fin);
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

### rtl/imu_sample_calibrator_unit.sv
// Coefficient writes and dropped samples are done on acceptance; a sample fetches its 24
// table entries, then takes the drift pass and the matrix (three row passes and a vector
// pass) when present and enabled, and then registers its result.
// The unit takes one item at a time; a held result does not stall the next beat, but
// the next result waits until the held one is taken.
// Reset: synchronous active low; clears control and warmup, then zeroes all 48 table entries.
`include "imu_sample_calibrator_unit_macros.svh"
module imu_sample_calibrator_unit
    import isc_pkg::*;
#(
    parameter int WARMUP_SAMPLES = WarmupSamplesDef,
    parameter int COEFF_WIDTH    = CoeffWidthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [0:0]  i_cfg_data
);
    localparam int CwEff = (COEFF_WIDTH < 32) ? COEFF_WIDTH : 32;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_DRIFT = 7'b0001000,
        S_MAT   = 7'b0010000,
        S_DOT   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state             r_state;
    logic [5:0]         r_clr;
    logic [4:0]         r_warm;
    logic               r_drift_en, r_asm_en, r_present;
    logic               r_wait;
    logic [5:0]         r_fcnt;
    logic [5:0]         r_base;
    logic signed [31:0] r_c [24];
    logic signed [31:0] r_v [3];
    logic signed [31:0] r_m [9];
    logic               r_kind;
    logic signed [31:0] r_temp;
    logic [31:0]        r_time;
    logic               r_ovalid;
    t_out_item          r_odata;
    logic [1:0]         r_mrow;

    logic               w_we;
    logic [5:0]         w_waddr;
    logic [31:0]        w_wdata;
    logic [31:0]        w_rdata;
    logic               w_acc;
    logic               w_sample_ok;
    t_lane_ctl          w_ctl;
    logic [2:0]         w_done;
    logic signed [31:0] w_res [3];
    logic signed [31:0] w_a [3][3];
    logic signed [31:0] w_b [3][3];
    logic signed [31:0] w_bs [3];
    logic signed [31:0] w_gain;
    logic [4:0]         w_rbase;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;
    assign w_sample_ok = (i_data.sensor_kind == KindAccel) ||
                         (i_data.sensor_kind == KindGyro);
    assign w_gain = (i_data.sensor_kind == KindAccel) ? 32'sd12 : 32'sd2000;
    assign w_rbase = {3'b000, r_mrow} + {2'b00, r_mrow, 1'b0};

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else begin
            w_we    = w_acc && i_data.action && (i_data.coeff_index < 6'(TableDepth));
            w_waddr = i_data.coeff_index;
            w_wdata = 32'(signed'(i_data.coeff_value[CwEff-1:0]));
        end
    end

    isc_ram #(.WIDTH(32), .DEPTH(TableDepth)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_base + r_fcnt),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_ctl.start = 1'b0;
        w_ctl.op    = LOP_DRIFT;
        for (int l = 0; l < 3; l++) begin
            w_a[l][0] = r_c[18 + l];
            w_a[l][1] = r_c[21 + l];
            w_a[l][2] = '0;
            w_b[l][0] = r_temp;
            w_b[l][1] = 32'sh10000;
            w_b[l][2] = '0;
            w_bs[l]   = r_v[l];
        end
        if (r_state == S_MAT) begin
            w_ctl.op = LOP_MAT;
            for (int l = 0; l < 3; l++) begin
                w_a[l][0] = r_c[w_rbase];
                w_a[l][1] = r_c[w_rbase + 5'd1];
                w_a[l][2] = r_c[w_rbase + 5'd2];
                w_b[l][0] = r_c[9 + l];
                w_b[l][1] = r_c[12 + l];
                w_b[l][2] = r_c[15 + l];
            end
        end else if (r_state == S_DOT) begin
            w_ctl.op = LOP_DOT;
            for (int l = 0; l < 3; l++) begin
                w_a[l][0] = r_m[3 * l];
                w_a[l][1] = r_m[3 * l + 1];
                w_a[l][2] = r_m[3 * l + 2];
                w_b[l][0] = r_v[0];
                w_b[l][1] = r_v[1];
                w_b[l][2] = r_v[2];
            end
        end
        w_ctl.start = (r_state == S_DRIFT || r_state == S_MAT || r_state == S_DOT)
                      && !r_wait;
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        isc_lane u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (w_ctl),
            .i_a0   (w_a[l][0]), .i_a1(w_a[l][1]), .i_a2(w_a[l][2]),
            .i_b0   (w_b[l][0]), .i_b1(w_b[l][1]), .i_b2(w_b[l][2]),
            .i_base (w_bs[l]),
            .o_done (w_done[l]),
            .o_res  (w_res[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_warm     <= '0;
            r_drift_en <= 1'b0;
            r_asm_en   <= 1'b0;
            r_present  <= 1'b0;
            r_ovalid   <= 1'b0;
            r_wait     <= 1'b0;
            r_fcnt     <= '0;
            r_mrow     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    RegDrift:    r_drift_en <= i_cfg_data[0];
                    RegAssembly: r_asm_en   <= i_cfg_data[0];
                    RegPresent:  r_present  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 6'd1;
                    if (r_clr == 6'(TableDepth - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc && !i_data.action && w_sample_ok) begin
                        if (32'(r_warm) < WARMUP_SAMPLES) begin
                            r_warm <= r_warm + 5'd1;
                        end else begin
                            r_kind <= (i_data.sensor_kind == KindGyro);
                            r_base <= (i_data.sensor_kind == KindGyro) ? 6'd24 : 6'd0;
                            r_temp <= (32'(i_data.raw_temperature) <<< 13)
                                      + 32'sd1507328;
                            r_time <= i_data.sample_time;
                            r_v[0] <= 32'(i_data.raw_axis_x) * w_gain;
                            r_v[1] <= 32'(i_data.raw_axis_y) * w_gain;
                            r_v[2] <= 32'(i_data.raw_axis_z) * w_gain;
                            r_fcnt <= '0;
                            r_state <= S_FETCH;
                        end
                    end
                end
                S_FETCH: begin
                    if (r_fcnt != 6'd24) begin
                        r_fcnt <= r_fcnt + 6'd1;
                    end
                    if (r_fcnt != 6'd0) begin
                        r_c[5'(r_fcnt - 6'd1)] <= w_rdata;
                    end
                    if (r_fcnt == 6'd24) begin
                        r_wait <= 1'b0;
                        r_mrow <= '0;
                        if (r_present && r_drift_en) begin
                            r_state <= S_DRIFT;
                        end else if (r_present && r_asm_en) begin
                            r_state <= S_MAT;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_DRIFT: begin
                    r_wait <= 1'b1;
                    if (w_done[0]) begin
                        for (int l = 0; l < 3; l++) r_v[l] <= w_res[l];
                        r_wait <= 1'b0;
                        r_state <= (r_present && r_asm_en) ? S_MAT : S_OUT;
                    end
                end
                S_MAT: begin
                    r_wait <= 1'b1;
                    if (w_done[0]) begin
                        for (int l = 0; l < 3; l++) r_m[w_rbase[3:0] + 4'(l)] <= w_res[l];
                        r_wait <= 1'b0;
                        r_mrow <= r_mrow + 2'd1;
                        if (r_mrow == 2'd2) begin
                            r_state <= S_DOT;
                        end
                    end
                end
                S_DOT: begin
                    r_wait <= 1'b1;
                    if (w_done[0]) begin
                        for (int l = 0; l < 3; l++) r_v[l] <= w_res[l];
                        r_wait <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= '{out_kind: r_kind, out_x: r_v[0], out_y: r_v[1],
                                      out_z: r_v[2], out_temperature: r_temp,
                                      out_time: r_time};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    `ISC_ASSERT_IMP(a_lanes_sync, i_clk, i_rst_n, 1'b1, w_done == 3'b000 || w_done == 3'b111)
    `ISC_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !w_acc)
    `ISC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ovalid && !i_ready, r_ovalid && $stable(r_odata))
endmodule

### dv/tb.sv
// Testbench for imu_sample_calibrator_unit: random and directed samples and
// coefficient writes, checked against an in-bench predictor. Depends on isc_pkg and the DUT.
module tb;
    import isc_pkg::*;

    localparam int InBits = $bits(t_in_item);

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_in_item   i_data = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_out_item  o_data;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [0:0] i_cfg_data = '0;

    imu_sample_calibrator_unit dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic signed [31:0] coeff_tab [48];
    int unsigned        warmup_seen;
    bit                 drift_on, assembly_on, present_on;
    t_out_item          expected_q [$];
    int                 mismatches;
    int                 send_idle_pct, recv_idle_pct;
    longint             cycle_count;

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rshift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint dot_q(longint a0, longint a1, longint a2,
                                     longint b0, longint b1, longint b2);
        longint acc;
        acc = fshift(a0 * b0, 2) + fshift(a1 * b1, 2) + fshift(a2 * b2, 2);
        return clamp32(rshift(acc, 22));
    endfunction

    task automatic predict_calibration(input t_in_item it);
        longint    tq, gain, corr;
        longint    v [3];
        longint    r [3];
        longint    m [3][3];
        int        base;
        t_out_item res;
        if (it.action) begin
            if (it.coeff_index < 48) coeff_tab[it.coeff_index] = it.coeff_value;
            return;
        end
        if (it.sensor_kind != KindAccel && it.sensor_kind != KindGyro) return;
        if (warmup_seen < WarmupSamplesDef) begin
            warmup_seen++;
            return;
        end
        tq = longint'(it.raw_temperature) * 8192 + 23 * 65536;
        gain = (it.sensor_kind == KindAccel) ? 12 : 2000;
        base = (it.sensor_kind == KindAccel) ? 0 : 24;
        v[0] = longint'(it.raw_axis_x) * gain;
        v[1] = longint'(it.raw_axis_y) * gain;
        v[2] = longint'(it.raw_axis_z) * gain;
        if (present_on && drift_on) begin
            for (int i = 0; i < 3; i++) begin
                corr = longint'(coeff_tab[base + 18 + i]) * tq
                     + longint'(coeff_tab[base + 21 + i]) * 65536;
                v[i] = clamp32(v[i] - rshift(corr, 24));
            end
        end
        if (present_on && assembly_on) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    m[i][j] = dot_q(coeff_tab[base + i*3], coeff_tab[base + i*3 + 1],
                                    coeff_tab[base + i*3 + 2], coeff_tab[base + 9 + j],
                                    coeff_tab[base + 12 + j], coeff_tab[base + 15 + j]);
            for (int i = 0; i < 3; i++)
                r[i] = dot_q(m[i][0], m[i][1], m[i][2], v[0], v[1], v[2]);
            for (int i = 0; i < 3; i++) v[i] = r[i];
        end
        res.out_kind = (it.sensor_kind == KindGyro);
        res.out_x = v[0][31:0];
        res.out_y = v[1][31:0];
        res.out_z = v[2][31:0];
        res.out_temperature = tq[31:0];
        res.out_time = it.sample_time;
        expected_q.insert(expected_q.size(), res);
    endtask

    // The beat stays valid after acceptance until the next call or an idle task drops it.
    task automatic send_beat(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_calibration(it);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (i_rst_n) i_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_data);
            end else begin
                if (o_data !== expected_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %p got %p", expected_q[0], o_data);
                end
                void'(expected_q.pop_front());
            end
        end
    end

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input bit val);
        i_valid <= 1'b0;
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            RegDrift:    drift_on = val;
            RegAssembly: assembly_on = val;
            RegPresent:  present_on = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_in_item random_sample();
        t_in_item it;
        it = InBits'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.action = 1'b0;
        it.sensor_kind = 8'($urandom_range(1, 2));
        if ($urandom_range(9) == 0) it.sensor_kind = 8'($urandom);
        if ($urandom_range(9) == 0) it.raw_axis_x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        return it;
    endfunction

    function automatic t_in_item coeff_write(input int idx, input logic [31:0] val);
        t_in_item it;
        it = InBits'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.action = 1'b1;
        it.coeff_index = 6'(idx);
        it.coeff_value = val;
        return it;
    endfunction

    function automatic logic [31:0] random_coeff();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h0100_0000;
            2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    task automatic test_warmup_and_extremes();
        t_in_item it;
        it = random_sample();
        it.sensor_kind = 8'd0;
        send_beat(it);
        it.sensor_kind = 8'd255;
        send_beat(it);
        send_beat(coeff_write(50, 32'h1234_5678));
        for (int i = 0; i < WarmupSamplesDef; i++) send_beat(random_sample());
        it = random_sample();
        it.raw_temperature = 16'sh8000;
        it.raw_axis_x = 16'sh8000; it.raw_axis_y = 16'sh7fff; it.raw_axis_z = '0;
        send_beat(it);
        it.raw_temperature = 16'sh7fff;
        it.sensor_kind = KindGyro;
        it.sample_time = 32'hffff_ffff;
        send_beat(it);
        drain_results();
    endtask

    task automatic test_unloaded_table();
        write_register(RegDrift, 1'b1);
        write_register(RegAssembly, 1'b1);
        write_register(RegPresent, 1'b1);
        for (int i = 0; i < 4; i++) send_beat(random_sample());
        drain_results();
    endtask

    task automatic test_random_calibration(input int n_items, input int s_pct,
                                           input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < 48; i++) send_beat(coeff_write(i, random_coeff()));
        for (int k = 0; k < 8; k++) begin
            write_register(RegDrift, 1'($urandom_range(1)));
            write_register(RegAssembly, 1'($urandom_range(1)));
            write_register(RegPresent, ($urandom_range(3) != 0));
            for (int i = 0; i < n_items / 8; i++) begin
                if ($urandom_range(9) == 0)
                    send_beat(coeff_write($urandom_range(63), random_coeff()));
                else
                    send_beat(random_sample());
            end
            drain_results();
        end
    endtask

    initial begin
        cycle_count = 0;
        mismatches = 0;
        warmup_seen = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (coeff_tab[i]) coeff_tab[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (60) @(posedge i_clk);
        test_warmup_and_extremes();
        test_unloaded_table();
        test_random_calibration(550, 19, 69);
        test_random_calibration(550, 69, 19);
        test_random_calibration(550, 0, 0);
        drain_results();
        if (mismatches == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule

### imu_sample_calibrator_unit.f
+incdir+rtl
rtl/isc_pkg.sv
rtl/isc_ram.sv
rtl/isc_lane.sv
rtl/imu_sample_calibrator_unit.sv
dv/tb.sv
